// File: hw/rtl/pfc_pkg.sv
// Playfair cipher core: shared types, constants and helper functions.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

  // Square geometry and alphabet
  localparam int SIDE    = 5;
  localparam int CELLS   = SIDE * SIDE;
  localparam int LETTERS = 26;

  typedef logic [4:0] letter_t;   // letter code, 0=a .. 25=z (31 on the wire)
  typedef logic [4:0] idx_t;      // cell index row*SIDE+col, or fill count 0..CELLS
  typedef logic [2:0] coord_t;    // row or column, 0..SIDE (SIDE only for a full square)

  localparam letter_t CODE_I = letter_t'(8);
  localparam letter_t CODE_J = letter_t'(9);

  // Command codes on the input channel
  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_KEY    = 3'd1,
    CMD_FINISH = 3'd2,
    CMD_ENC    = 3'd3,
    CMD_DEC    = 3'd4
  } command_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_LETTER = 2'd1,
    ST_NOT_FULL   = 2'd2
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // take the input item
    logic exec;      // decode the item, run key commands
    logic fin_step;  // place one alphabet letter while finishing the key
    logic look1;     // look up the square position of the first letter
    logic look2;     // look up the square position of the second letter
    logic read1;     // read the first result letter from the square
    logic read2;     // read the second result letter from the square
    logic emit;      // move the result into the output register
  } pfc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_finish; // held item is a finish-key command
    logic pair_ok;   // held item is a pair that can be looked up
    logic fin_last;  // finish walk is at the last alphabet letter
    logic out_free;  // output register can take a result this cycle
  } pfc_stat_t;

  // Fold j onto i
  function automatic letter_t fold_letter(letter_t c);
    return (c == CODE_J) ? CODE_I : c;
  endfunction

  // One place forward (encrypt) or back (decrypt), wrapping round
  function automatic coord_t step_coord(coord_t c, logic back);
    if (back) begin
      return (c == '0) ? coord_t'(SIDE - 1) : coord_t'(c - 1'b1);
    end else begin
      return (c == coord_t'(SIDE - 1)) ? '0 : coord_t'(c + 1'b1);
    end
  endfunction

  // Row-major cell index
  function automatic idx_t cell_index(coord_t row, coord_t col);
    return idx_t'(idx_t'(row) * idx_t'(SIDE) + idx_t'(col));
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pfc_if.sv
// Playfair cipher core: valid/ready channel interfaces for items in and results out.
// Depends on pfc_pkg for the letter type.
`timescale 1ns / 1ps
`default_nettype none

interface pfc_in_if;
  logic             valid;
  logic             ready;
  logic [2:0]       command;
  pfc_pkg::letter_t letter_first;
  pfc_pkg::letter_t letter_second;

  modport source (output valid, output command, output letter_first,
                  output letter_second, input ready);
  modport sink   (input valid, input command, input letter_first,
                  input letter_second, output ready);
endinterface

interface pfc_out_if;
  logic             valid;
  logic             ready;
  pfc_pkg::letter_t out_first;
  pfc_pkg::letter_t out_second;
  logic [1:0]       status;

  modport source (output valid, output out_first, output out_second,
                  output status, input ready);
  modport sink   (input valid, input out_first, input out_second,
                  input status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pfc_ctrl.sv
// Playfair cipher core: controller state machine sequencing one item at a time.
// Depends on pfc_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module pfc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pfc_pkg::pfc_stat_t stat,
  output pfc_pkg::pfc_cmd_t       cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_FINISH = 7'b0000100,
    S_LOOK1  = 7'b0001000,
    S_LOOK2  = 7'b0010000,
    S_READ   = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   second_r, second_nxt;   // in S_READ: first or second result letter

  // Next state and command decode
  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        priority if (stat.is_finish) begin
          state_nxt = S_FINISH;
        end else if (stat.pair_ok) begin
          state_nxt = S_LOOK1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_FINISH: begin
        cmd.fin_step = 1'b1;
        if (stat.fin_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_LOOK1: begin
        cmd.look1 = 1'b1;
        state_nxt = S_LOOK2;
      end
      S_LOOK2: begin
        cmd.look2  = 1'b1;
        second_nxt = 1'b0;
        state_nxt  = S_READ;
      end
      S_READ: begin
        cmd.read1  = !second_r;
        cmd.read2  = second_r;
        second_nxt = 1'b1;
        if (second_r) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

`ifndef SYNTHESIS
  // A taken item is decoded in the very next cycle
  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec)
    else $error("item taken but not decoded in the next cycle");

  // The first result letter is always followed by the second
  a_read_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.read1 |=> cmd.read2)
    else $error("second square read missing after the first");

  // Exactly one state bit is set
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state is not one-hot");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/pfc_datapath.sv
// Playfair cipher core: key square, letter positions, lookup and output register.
// Depends on pfc_pkg; driven by pfc_ctrl through pfc_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module pfc_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [2:0]        in_command,
  input  wire pfc_pkg::letter_t  in_letter_first,
  input  wire pfc_pkg::letter_t  in_letter_second,
  input  wire pfc_pkg::pfc_cmd_t cmd,
  output pfc_pkg::pfc_stat_t     stat,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output pfc_pkg::letter_t       out_first,
  output pfc_pkg::letter_t       out_second,
  output logic [1:0]             out_status
);

  // Held item
  logic [2:0]       cmd_r;
  pfc_pkg::letter_t a_r, b_r;

  // Key state
  logic [pfc_pkg::LETTERS-1:0] used_r;
  pfc_pkg::idx_t               fill_r;
  pfc_pkg::coord_t             fill_row_r, fill_col_r;
  pfc_pkg::letter_t            square_r    [pfc_pkg::CELLS];
  pfc_pkg::coord_t             place_row_r [pfc_pkg::LETTERS];
  pfc_pkg::coord_t             place_col_r [pfc_pkg::LETTERS];
  pfc_pkg::letter_t            fin_cnt_r;

  // Lookup and result
  pfc_pkg::coord_t  r1_r, c1_r, r2_r, c2_r;
  pfc_pkg::letter_t res_first_r, res_second_r;
  logic [1:0]       res_status_r;
  logic             out_valid_r;
  pfc_pkg::letter_t out_first_r, out_second_r;
  logic [1:0]       out_status_r;

  logic             is_key, is_pair, is_clear, is_back;
  logic             a_ok, b_ok, sq_full;
  pfc_pkg::status_t exec_status;
  pfc_pkg::letter_t place_letter, look_letter;
  logic             place_req, place_en;
  pfc_pkg::coord_t  n1r, n1c, n2r, n2c;
  pfc_pkg::idx_t    sq_addr;
  pfc_pkg::letter_t sq_data;
  logic             out_free;

  // Decode the held item
  assign is_key   = (cmd_r == pfc_pkg::CMD_KEY);
  assign is_pair  = (cmd_r == pfc_pkg::CMD_ENC) || (cmd_r == pfc_pkg::CMD_DEC);
  assign is_clear = (cmd_r == pfc_pkg::CMD_CLEAR);
  assign is_back  = (cmd_r == pfc_pkg::CMD_DEC);
  assign a_ok     = (a_r < pfc_pkg::letter_t'(pfc_pkg::LETTERS));
  assign b_ok     = (b_r < pfc_pkg::letter_t'(pfc_pkg::LETTERS));
  assign sq_full  = (fill_r == pfc_pkg::idx_t'(pfc_pkg::CELLS));

  // Status of the item: letter check comes before the square check
  always_comb begin
    priority if ((is_key && !a_ok) || (is_pair && (!a_ok || !b_ok))) begin
      exec_status = pfc_pkg::ST_BAD_LETTER;
    end else if (is_pair && !sq_full) begin
      exec_status = pfc_pkg::ST_NOT_FULL;
    end else begin
      exec_status = pfc_pkg::ST_OK;
    end
  end

  // Place one letter: key letter on decode, or the alphabet walk on finish
  assign place_letter = cmd.fin_step ? fin_cnt_r : pfc_pkg::fold_letter(a_r);
  assign place_req    = (cmd.exec && is_key && a_ok) ||
                        (cmd.fin_step && (fin_cnt_r != pfc_pkg::CODE_J));
  assign place_en     = place_req && !used_r[place_letter] && !sq_full;

  // Position lookup, one letter a cycle
  assign look_letter = pfc_pkg::fold_letter(cmd.look2 ? b_r : a_r);

  // Apply the row, column or rectangle rule
  always_comb begin
    priority if (r1_r == r2_r) begin
      n1r = r1_r; n1c = pfc_pkg::step_coord(c1_r, is_back);
      n2r = r2_r; n2c = pfc_pkg::step_coord(c2_r, is_back);
    end else if (c1_r == c2_r) begin
      n1r = pfc_pkg::step_coord(r1_r, is_back); n1c = c1_r;
      n2r = pfc_pkg::step_coord(r2_r, is_back); n2c = c2_r;
    end else begin
      n1r = r1_r; n1c = c2_r;
      n2r = r2_r; n2c = c1_r;
    end
  end

  // Square read, one cell a cycle
  assign sq_addr = cmd.read2 ? pfc_pkg::cell_index(n2r, n2c) : pfc_pkg::cell_index(n1r, n1c);
  assign sq_data = square_r[sq_addr];

  assign out_free = !out_valid_r || out_ready;

  // Status back to the controller
  always_comb begin
    stat           = '0;
    stat.is_finish = (cmd_r == pfc_pkg::CMD_FINISH);
    stat.pair_ok   = is_pair && a_ok && b_ok && sq_full;
    stat.fin_last  = (fin_cnt_r == pfc_pkg::letter_t'(pfc_pkg::LETTERS - 1));
    stat.out_free  = out_free;
  end

  // Key control state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      fill_r      <= '0;
      fill_row_r  <= '0;
      fill_col_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec && is_clear) begin
        used_r     <= '0;
        fill_r     <= '0;
        fill_row_r <= '0;
        fill_col_r <= '0;
      end else if (place_en) begin
        used_r[place_letter] <= 1'b1;
        fill_r               <= pfc_pkg::idx_t'(fill_r + 1'b1);
        if (fill_col_r == pfc_pkg::coord_t'(pfc_pkg::SIDE - 1)) begin
          fill_col_r <= '0;
          fill_row_r <= pfc_pkg::coord_t'(fill_row_r + 1'b1);
        end else begin
          fill_col_r <= pfc_pkg::coord_t'(fill_col_r + 1'b1);
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: held item, square contents, lookups and results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      a_r   <= in_letter_first;
      b_r   <= in_letter_second;
    end
    if (place_en) begin
      square_r[fill_r]          <= place_letter;
      place_row_r[place_letter] <= fill_row_r;
      place_col_r[place_letter] <= fill_col_r;
    end
    if (cmd.exec) begin
      fin_cnt_r    <= '0;
      res_first_r  <= '0;
      res_second_r <= '0;
      res_status_r <= exec_status;
    end
    if (cmd.fin_step) begin
      fin_cnt_r <= pfc_pkg::letter_t'(fin_cnt_r + 1'b1);
    end
    if (cmd.look1) begin
      r1_r <= place_row_r[look_letter];
      c1_r <= place_col_r[look_letter];
    end
    if (cmd.look2) begin
      r2_r <= place_row_r[look_letter];
      c2_r <= place_col_r[look_letter];
    end
    if (cmd.read1) begin
      res_first_r <= sq_data;
    end
    if (cmd.read2) begin
      res_second_r <= sq_data;
    end
    if (cmd.emit) begin
      out_first_r  <= res_first_r;
      out_second_r <= res_second_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_first  = out_first_r;
  assign out_second = out_second_r;
  assign out_status = out_status_r;

`ifndef SYNTHESIS
  // Fill count matches the fill row and column
  a_fill_coords: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == pfc_pkg::cell_index(fill_row_r, fill_col_r))
    else $error("fill count out of step with fill row and column");

  // Every placed letter is marked used, and nothing else
  a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == 32'(fill_r))
    else $error("used letters disagree with fill count");

  // Never overwrite a result that has not been taken
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("result emitted over a waiting result");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/playfair_digraph_cipher_core.sv
// Playfair cipher core top level: joins the controller and the datapath to the channels.
// Depends on pfc_pkg, pfc_if (pfc_in_if, pfc_out_if), pfc_ctrl and pfc_datapath.
//
//   channel  | dir | payload                                   | handshake
//   ---------+-----+-------------------------------------------+-------------
//   in_ch    | in  | command, letter_first, letter_second      | valid/ready
//   out_ch   | out | out_first, out_second, status             | valid/ready
//
// One item at a time: clear, key letter, bad letters, pairs on an unfinished square
// and unused commands go from decode straight to the result, an encrypt or decrypt
// pair adds two position lookups and two square reads through single read ports,
// and finish key adds the walk over 26 alphabet letters, one a cycle.
// A finished result waits in the output register while the next item is taken.
// Synchronous active-low reset empties the key square and the output register.
`timescale 1ns / 1ps
`default_nettype none

module playfair_digraph_cipher_core (
  input  wire logic clk,
  input  wire logic rst_n,
  pfc_in_if.sink    in_ch,
  pfc_out_if.source out_ch
);

  pfc_pkg::pfc_cmd_t  cmd;
  pfc_pkg::pfc_stat_t stat;

  // Sequencing
  pfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Key square, lookups and result register
  pfc_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_ch.command),
    .in_letter_first  (in_ch.letter_first),
    .in_letter_second (in_ch.letter_second),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_first        (out_ch.out_first),
    .out_second       (out_ch.out_second),
    .out_status       (out_ch.status)
  );

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking bench for the Playfair digraph cipher core: key building, finishing,
// pair encrypt/decrypt and error statuses, compared result by result with a tracker.
// Depends on pfc_pkg, pfc_if (pfc_in_if, pfc_out_if) and playfair_digraph_cipher_core.
`timescale 1ns / 1ps

typedef struct {
  pfc_pkg::letter_t first;
  pfc_pkg::letter_t second;
  pfc_pkg::status_t st;
} cipher_result_t;

// Track the key square and hold the results still to come
class cipher_tracker;
  pfc_pkg::letter_t square [pfc_pkg::CELLS];
  bit               placed [pfc_pkg::LETTERS];
  pfc_pkg::idx_t    spot   [pfc_pkg::LETTERS];
  int               fill;
  cipher_result_t   awaited [$];
  int               n_inputs;
  int               n_pairs;
  int               n_flagged;
  int               n_errors;

  function new();
    wipe();
    n_inputs  = 0;
    n_pairs   = 0;
    n_flagged = 0;
    n_errors  = 0;
  endfunction

  function void wipe();
    for (int k = 0; k < pfc_pkg::CELLS; k++) square[k] = '0;
    for (int k = 0; k < pfc_pkg::LETTERS; k++) begin
      placed[k] = 1'b0;
      spot[k]   = '0;
    end
    fill = 0;
  endfunction

  function pfc_pkg::letter_t fold_j(pfc_pkg::letter_t c);
    if (c == pfc_pkg::CODE_J) return pfc_pkg::CODE_I;
    return c;
  endfunction

  // Append a letter unless it is out of range, already placed, or the square is full
  function void place(int c);
    if (c >= pfc_pkg::LETTERS || placed[c] || fill >= pfc_pkg::CELLS) return;
    square[fill] = pfc_pkg::letter_t'(c);
    spot[c]      = pfc_pkg::idx_t'(fill);
    placed[c]    = 1'b1;
    fill++;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  // Work out the result of one accepted item and queue it
  function void note_input(logic [2:0] cmd, pfc_pkg::letter_t a, pfc_pkg::letter_t b);
    cipher_result_t r;
    int p1, p2, r1, c1, r2, c2, d, n1r, n1c, n2r, n2c;
    r.first  = '0;
    r.second = '0;
    r.st     = pfc_pkg::ST_OK;
    n_inputs++;
    case (cmd)
      pfc_pkg::CMD_CLEAR: wipe();
      pfc_pkg::CMD_KEY: begin
        if (a >= pfc_pkg::LETTERS) r.st = pfc_pkg::ST_BAD_LETTER;
        else place(fold_j(a));
      end
      pfc_pkg::CMD_FINISH: begin
        for (int c = 0; c < pfc_pkg::LETTERS; c++)
          if (c != pfc_pkg::CODE_J) place(c);
      end
      pfc_pkg::CMD_ENC, pfc_pkg::CMD_DEC: begin
        if (a >= pfc_pkg::LETTERS || b >= pfc_pkg::LETTERS) begin
          r.st = pfc_pkg::ST_BAD_LETTER;
        end else if (fill < pfc_pkg::CELLS) begin
          r.st = pfc_pkg::ST_NOT_FULL;
        end else begin
          p1 = int'(spot[fold_j(a)]) % pfc_pkg::CELLS;
          p2 = int'(spot[fold_j(b)]) % pfc_pkg::CELLS;
          r1 = p1 / pfc_pkg::SIDE;
          c1 = p1 % pfc_pkg::SIDE;
          r2 = p2 / pfc_pkg::SIDE;
          c2 = p2 % pfc_pkg::SIDE;
          // one place on to encrypt, one place back to decrypt
          d = (cmd == pfc_pkg::CMD_ENC) ? 1 : pfc_pkg::SIDE - 1;
          if (r1 == r2) begin
            n1r = r1; n1c = (c1 + d) % pfc_pkg::SIDE;
            n2r = r2; n2c = (c2 + d) % pfc_pkg::SIDE;
          end else if (c1 == c2) begin
            n1r = (r1 + d) % pfc_pkg::SIDE; n1c = c1;
            n2r = (r2 + d) % pfc_pkg::SIDE; n2c = c2;
          end else begin
            n1r = r1; n1c = c2;
            n2r = r2; n2c = c1;
          end
          r.first  = square[n1r * pfc_pkg::SIDE + n1c];
          r.second = square[n2r * pfc_pkg::SIDE + n2c];
          n_pairs++;
        end
      end
      default: ;
    endcase
    if (r.st != pfc_pkg::ST_OK) n_flagged++;
    awaited.push_back(r);
  endfunction

  // Compare one result with the oldest one awaited
  function void check_result(pfc_pkg::letter_t f, pfc_pkg::letter_t s, logic [1:0] st);
    cipher_result_t e;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected result first %0d second %0d status %0d", $time, f, s, st);
      n_errors++;
      return;
    end
    e = awaited.pop_front();
    if (f !== e.first) begin
      $display("%0t: out_first expected %0d actual %0d", $time, e.first, f);
      n_errors++;
    end
    if (s !== e.second) begin
      $display("%0t: out_second expected %0d actual %0d", $time, e.second, s);
      n_errors++;
    end
    if (st !== e.st) begin
      $display("%0t: status expected %0d actual %0d", $time, e.st, st);
      n_errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int ITEM_TARGET     = 1850;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int HOLD_OFF_AFTER  = 600;
  localparam int DRAIN_AFTER     = 900;
  localparam int SETTLE_CYCLES   = 40;

  logic clk;
  logic rst_n;
  int   n_sent;
  int   burst_left;
  int   quiet_cycles;
  bit   held_off;
  bit   drained;

  cipher_tracker sb;

  pfc_in_if  in_ch ();
  pfc_out_if out_ch ();

  playfair_digraph_cipher_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock, 4 ns period
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sample both channels at the rising edge and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.out_first, out_ch.out_second, out_ch.status);
      if (in_ch.valid && in_ch.ready)
        sb.note_input(in_ch.command, in_ch.letter_first, in_ch.letter_second);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Receiver: stall on changing patterns, with one long hold-off
  initial begin
    int mode;
    int stretch;
    int phase;
    out_ch.ready = 1'b0;
    mode     = 0;
    stretch  = 0;
    phase    = 0;
    held_off = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && sb != null && sb.n_inputs >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(0, 3);
          stretch = $urandom_range(20, 200);
        end
        stretch--;
        phase++;
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 99) < 85);
          default: out_ch.ready <= ((phase % 4) != 0);
        endcase
      end
    end
  end

  // Drop valid and wait, with junk on the payload
  task automatic rest(input int n);
    in_ch.valid         <= 1'b0;
    in_ch.command       <= 3'($urandom_range(0, 7));
    in_ch.letter_first  <= pfc_pkg::letter_t'($urandom_range(0, 31));
    in_ch.letter_second <= pfc_pkg::letter_t'($urandom_range(0, 31));
    repeat (n) @(negedge clk);
  endtask

  // Hold off until every awaited result has come
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // Offer one item, wait for acceptance, then end the burst when due
  task automatic offer(input logic [2:0] cmd, input pfc_pkg::letter_t a,
                       input pfc_pkg::letter_t b);
    int gap;
    in_ch.command       <= cmd;
    in_ch.letter_first  <= a;
    in_ch.letter_second <= b;
    in_ch.valid         <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    n_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        9:       gap = $urandom_range(20, 45);
        default: gap = $urandom_range(1, 8);
      endcase
      if (gap > 0) rest(gap);
    end
  endtask

  // Mostly a valid letter, now and then a code past z
  function automatic pfc_pkg::letter_t pick_letter(int bad_pct);
    if ($urandom_range(0, 99) < bad_pct) return pfc_pkg::letter_t'($urandom_range(26, 31));
    return pfc_pkg::letter_t'($urandom_range(0, 25));
  endfunction

  function automatic pfc_pkg::letter_t any_code();
    return pfc_pkg::letter_t'($urandom_range(0, 31));
  endfunction

  // Build a key, finish it and cipher a run of pairs, with some noise mixed in
  task automatic keyed_session();
    int n_keys;
    int n_pair_items;
    offer(pfc_pkg::CMD_CLEAR, any_code(), any_code());
    n_keys = $urandom_range(0, 12);
    for (int k = 0; k < n_keys; k++) offer(pfc_pkg::CMD_KEY, pick_letter(5), any_code());
    offer(pfc_pkg::CMD_FINISH, any_code(), any_code());
    n_pair_items = $urandom_range(4, 40);
    for (int k = 0; k < n_pair_items; k++) begin
      case ($urandom_range(0, 24))
        0:       offer(3'($urandom_range(5, 7)), any_code(), any_code());
        1:       offer(pfc_pkg::CMD_KEY, any_code(), any_code());
        2:       offer(pfc_pkg::CMD_FINISH, any_code(), any_code());
        default: offer(($urandom_range(0, 1) != 0) ? pfc_pkg::CMD_ENC : pfc_pkg::CMD_DEC,
                       pick_letter(4), pick_letter(4));
      endcase
    end
  endtask

  // Half-built squares and plain noise
  task automatic broken_session();
    int n_items;
    n_items = $urandom_range(3, 15);
    if ($urandom_range(0, 1) != 0) begin
      offer(pfc_pkg::CMD_CLEAR, any_code(), any_code());
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 2) == 0) offer(pfc_pkg::CMD_KEY, pick_letter(10), any_code());
        else offer(($urandom_range(0, 1) != 0) ? pfc_pkg::CMD_ENC : pfc_pkg::CMD_DEC,
                   pick_letter(10), pick_letter(10));
      end
    end else begin
      for (int k = 0; k < n_items; k++) offer(3'($urandom_range(0, 7)), any_code(), any_code());
    end
  endtask

  initial begin
    sb           = new();
    n_sent       = 0;
    burst_left   = 1;
    quiet_cycles = 0;
    drained      = 1'b0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.command       = '0;
    in_ch.letter_first  = '0;
    in_ch.letter_second = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty square, key building corner cases, each pair rule, bad codes
    offer(pfc_pkg::CMD_ENC, 5'd0, 5'd1);           // square not finished
    offer(pfc_pkg::CMD_ENC, 5'd31, 5'd0);          // bad code wins over unfinished square
    offer(pfc_pkg::CMD_KEY, 5'd15, 5'd0);          // p
    offer(pfc_pkg::CMD_KEY, 5'd11, 5'd31);         // l
    offer(pfc_pkg::CMD_KEY, 5'd0, 5'd0);           // a
    offer(pfc_pkg::CMD_KEY, 5'd24, 5'd0);          // y
    offer(pfc_pkg::CMD_KEY, 5'd15, 5'd0);          // repeated letter
    offer(pfc_pkg::CMD_KEY, 5'd31, 5'd0);          // code past z
    offer(pfc_pkg::CMD_KEY, 5'd9, 5'd0);           // j folds to i
    offer(pfc_pkg::CMD_KEY, 5'd26, 5'd0);
    offer(pfc_pkg::CMD_FINISH, 5'd0, 5'd0);
    offer(pfc_pkg::CMD_KEY, 5'd3, 5'd0);           // square already full
    offer(pfc_pkg::CMD_FINISH, 5'd31, 5'd31);      // finish on a full square
    offer(pfc_pkg::CMD_ENC, 5'd15, 5'd11);         // same row
    offer(pfc_pkg::CMD_DEC, 5'd15, 5'd11);
    offer(pfc_pkg::CMD_ENC, 5'd15, 5'd1);          // same column
    offer(pfc_pkg::CMD_DEC, 5'd15, 5'd1);
    offer(pfc_pkg::CMD_ENC, 5'd0, 5'd25);          // rectangle
    offer(pfc_pkg::CMD_DEC, 5'd9, 5'd9);           // equal letters after folding
    offer(pfc_pkg::CMD_ENC, 5'd25, 5'd24);
    offer(pfc_pkg::CMD_DEC, 5'd0, 5'd31);          // bad second letter
    offer(3'd5, 5'd31, 5'd31);                     // unused commands
    offer(3'd6, 5'd0, 5'd0);
    offer(3'd7, 5'd31, 5'd0);
    offer(pfc_pkg::CMD_CLEAR, 5'd31, 5'd31);

    // Random sessions, mostly well formed
    while (n_sent < ITEM_TARGET) begin
      if (!drained && n_sent >= DRAIN_AFTER) begin
        drained = 1'b1;
        drain();
      end
      if ($urandom_range(0, 9) < 8) keyed_session();
      else broken_session();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending());
      sb.n_errors += sb.pending();
    end
    $display("Run covered %0d items: %0d pairs ciphered through a full square,",
             sb.n_inputs, sb.n_pairs);
    $display("%0d error statuses; receiver long hold-off done: %0d, sender drain done: %0d.",
             sb.n_flagged, held_off, drained);
    if (sb.n_errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
